>>> hdl/ftfm_pkg.sv
// ----------------------------------------------------------------------------
// ftfm_pkg
// Shared constants and types for the first-touch feature mask block.
// ----------------------------------------------------------------------------
package ftfm_pkg;

  localparam int SLOTS        = 3;
  localparam int VIDX_W       = 16;
  localparam int EIDX_W       = 17;
  localparam int MASK_W       = 6;
  localparam int ROW_BITS     = 6;
  localparam int ROW_W        = 1 << ROW_BITS;
  localparam int IN_DATA_W    = 104;
  localparam int OUT_DATA_W   = 8;

  localparam int VERTEX_COUNT_DEF = 65536;
  localparam int EDGE_COUNT_DEF   = 131072;

  // mask bit of the first vertex slot and of the first edge slot
  localparam int VERTEX_SLOT_BIT = 0;
  localparam int EDGE_SLOT_BIT   = 3;

  // tuser command codes
  localparam logic CMD_TRIANGLE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // RAM strobes handed from the sequencer to a group of lanes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ftfm_ram_ctl_t;

endpackage

>>> hdl/first_touch_feature_mask_top.sv
// ----------------------------------------------------------------------------
// first_touch_feature_mask_top
// Marks the vertices and edges of a mesh owned by the first triangle naming
// them and returns a 6-bit ownership mask per request.
// ----------------------------------------------------------------------------
// A triangle request runs these steps from acceptance to the next acceptance:
// one read of all six lanes, one merge step, three writes, one per slot (each lane
// keeps its own copy of its store behind a single write port and every copy
// must take the row updates of all three slots of its group), one hand-over
// step that loads the mask into the output register, and a return to idle with
// ready high. The hand-over waits while an earlier result is still held on
// the output. A clear request, and reset, sweep the stores one 64-bit row per
// cycle over max(VERTEX_COUNT, EDGE_COUNT) / 64 rows, rounded up (2048 at the
// defaults), during which no request is accepted. A clear request answers
// with a zero mask through the same hand-over after the sweep. A result
// waiting on the output does not stop the next request from being accepted.
module first_touch_feature_mask_top import ftfm_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int EDGE_COUNT   = EDGE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // vertex_a [15:0], vertex_b [31:16], vertex_c [47:32],
  // edge_a [64:48], edge_b [81:65], edge_c [98:82], zero [103:99]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command [0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // owner_mask [5:0], zero [7:6]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int VROWS   = (VERTEX_COUNT + ROW_W - 1) / ROW_W;
  localparam int EROWS   = (EDGE_COUNT + ROW_W - 1) / ROW_W;
  localparam int VAW     = (VROWS > 1) ? $clog2(VROWS) : 1;
  localparam int EAW     = (EROWS > 1) ? $clog2(EROWS) : 1;
  localparam int MAXROWS = (VROWS > EROWS) ? VROWS : EROWS;
  localparam int SW      = (VAW > EAW) ? VAW : EAW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  logic [2:0]                     state;
  logic [1:0]                     slot;
  logic [SW-1:0]                  sweep;
  logic                           clear_reply;
  logic [SLOTS-1:0][VIDX_W-1:0]   v_idx;
  logic [SLOTS-1:0][EIDX_W-1:0]   e_idx;
  logic [MASK_W-1:0]              mask;
  logic [MASK_W-1:0]              mask_next;
  logic [MASK_W-1:0]              owner_mask;
  logic [SLOTS-1:0][ROW_W-1:0]    v_new_q;
  logic [SLOTS-1:0][ROW_W-1:0]    e_new_q;

  logic                           s_accept;
  logic                           sweep_last;
  logic                           out_free;
  ftfm_ram_ctl_t                  v_ctl;
  ftfm_ram_ctl_t                  e_ctl;
  logic [VAW-1:0]                 v_wr_row;
  logic [EAW-1:0]                 e_wr_row;
  logic [ROW_W-1:0]               v_wr_data;
  logic [ROW_W-1:0]               e_wr_data;

  logic [SLOTS-1:0]               v_in_range;
  logic [SLOTS-1:0]               v_owned;
  logic [SLOTS-1:0][VAW-1:0]      v_row;
  logic [SLOTS-1:0][ROW_BITS-1:0] v_bit;
  logic [SLOTS-1:0][ROW_W-1:0]    v_rd;
  logic [SLOTS-1:0]               v_claim;
  logic [SLOTS-1:0][ROW_W-1:0]    v_new;

  logic [SLOTS-1:0]               e_in_range;
  logic [SLOTS-1:0]               e_owned;
  logic [SLOTS-1:0][EAW-1:0]      e_row;
  logic [SLOTS-1:0][ROW_BITS-1:0] e_bit;
  logic [SLOTS-1:0][ROW_W-1:0]    e_rd;
  logic [SLOTS-1:0]               e_claim;
  logic [SLOTS-1:0][ROW_W-1:0]    e_new;

  assign s_tready   = (state == ST_IDLE);
  assign s_accept   = s_tvalid && s_tready;
  assign sweep_last = (sweep == SW'(MAXROWS - 1));
  assign out_free   = !m_tvalid || m_tready;
  assign m_tdata    = OUT_DATA_W'(owner_mask);

  always_comb begin
    mask_next                         = '0;
    mask_next[VERTEX_SLOT_BIT +: SLOTS] = v_claim;
    mask_next[EDGE_SLOT_BIT +: SLOTS]   = e_claim;
  end

  // write port of each group: sweep rows while clearing, else slot rows
  always_comb begin
    v_ctl.rd_en = (state == ST_READ);
    e_ctl.rd_en = (state == ST_READ);
    if (state == ST_CLEAR) begin
      v_ctl.wr_en = 32'(sweep) < 32'(VROWS);
      e_ctl.wr_en = 32'(sweep) < 32'(EROWS);
      v_wr_row    = VAW'(sweep);
      e_wr_row    = EAW'(sweep);
      v_wr_data   = '0;
      e_wr_data   = '0;
    end else begin
      v_ctl.wr_en = (state == ST_WRITE) && v_in_range[slot];
      e_ctl.wr_en = (state == ST_WRITE) && e_in_range[slot];
      v_wr_row    = v_row[slot];
      e_wr_row    = e_row[slot];
      v_wr_data   = v_new_q[slot];
      e_wr_data   = e_new_q[slot];
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_lane
    ftfm_lane #(
      .IDX_W (VIDX_W),
      .COUNT (VERTEX_COUNT)
    ) u_vlane (
      .clk      (clk),
      .ctl      (v_ctl),
      .idx      (v_idx[k]),
      .wr_row   (v_wr_row),
      .wr_data  (v_wr_data),
      .in_range (v_in_range[k]),
      .row      (v_row[k]),
      .bit_sel  (v_bit[k]),
      .owned    (v_owned[k]),
      .rd_data  (v_rd[k])
    );

    ftfm_lane #(
      .IDX_W (EIDX_W),
      .COUNT (EDGE_COUNT)
    ) u_elane (
      .clk      (clk),
      .ctl      (e_ctl),
      .idx      (e_idx[k]),
      .wr_row   (e_wr_row),
      .wr_data  (e_wr_data),
      .in_range (e_in_range[k]),
      .row      (e_row[k]),
      .bit_sel  (e_bit[k]),
      .owned    (e_owned[k]),
      .rd_data  (e_rd[k])
    );
  end

  ftfm_merge #(.AW(VAW)) u_vmerge (
    .in_range (v_in_range),
    .owned    (v_owned),
    .row      (v_row),
    .bit_sel  (v_bit),
    .rd_data  (v_rd),
    .claim    (v_claim),
    .new_row  (v_new)
  );

  ftfm_merge #(.AW(EAW)) u_emerge (
    .in_range (e_in_range),
    .owned    (e_owned),
    .row      (e_row),
    .bit_sel  (e_bit),
    .rd_data  (e_rd),
    .claim    (e_claim),
    .new_row  (e_new)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      for (int k = 0; k < SLOTS; k++) begin
        v_idx[k] <= s_tdata[k*VIDX_W +: VIDX_W];
        e_idx[k] <= s_tdata[SLOTS*VIDX_W + k*EIDX_W +: EIDX_W];
      end
    end
    if (s_accept && s_tuser == CMD_CLEAR) begin
      mask <= '0;
    end else if (state == ST_EVAL) begin
      mask    <= mask_next;
      v_new_q <= v_new;
      e_new_q <= e_new;
    end
    if (state == ST_DONE && out_free) begin
      owner_mask <= mask;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      sweep       <= '0;
      slot        <= '0;
      clear_reply <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_tuser == CMD_CLEAR) begin
              state       <= ST_CLEAR;
              sweep       <= '0;
              clear_reply <= 1'b1;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= ST_WRITE;
          slot  <= '0;
        end
        ST_WRITE: begin
          if (slot == 2'(SLOTS - 1)) begin
            state <= ST_DONE;
          end else begin
            slot <= slot + 2'd1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          sweep <= sweep + SW'(1);
          if (sweep_last) begin
            state <= clear_reply ? ST_DONE : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser == CMD_CLEAR) |=> (state == ST_CLEAR && sweep == '0))
    else $error("clear request did not start a sweep");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside the hand-over state");

  a_claim_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> ((v_claim & ~v_in_range) == '0 && (e_claim & ~e_in_range) == '0))
    else $error("claim on an out-of-range index");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!v_ctl.rd_en && !e_ctl.rd_en && !s_tready))
    else $error("lookup or request during a clearing sweep");

endmodule

>>> hdl/ftfm_ram.sv
// ----------------------------------------------------------------------------
// ftfm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ftfm_lane.sv
// ----------------------------------------------------------------------------
// ftfm_lane
// One slot lane: own copy of the ownership store, index decode and lookup.
// ----------------------------------------------------------------------------
module ftfm_lane import ftfm_pkg::*; #(
  parameter int IDX_W = VIDX_W,
  parameter int COUNT = VERTEX_COUNT_DEF,
  localparam int ROWS = (COUNT + ROW_W - 1) / ROW_W,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                clk,
  input  ftfm_ram_ctl_t       ctl,
  input  logic [IDX_W-1:0]    idx,
  input  logic [AW-1:0]       wr_row,
  input  logic [ROW_W-1:0]    wr_data,
  output logic                in_range,
  output logic [AW-1:0]       row,
  output logic [ROW_BITS-1:0] bit_sel,
  output logic                owned,
  output logic [ROW_W-1:0]    rd_data
);

  assign in_range = 32'(idx) < 32'(COUNT);
  assign row      = AW'(32'(idx) >> ROW_BITS);
  assign bit_sel  = idx[ROW_BITS-1:0];
  assign owned    = rd_data[bit_sel];

  ftfm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_row),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (row),
    .rd_data (rd_data)
  );

endmodule

>>> hdl/ftfm_merge.sv
// ----------------------------------------------------------------------------
// ftfm_merge
// Combines the lanes of one group: resolves repeats within the triangle and
// builds the updated row for each slot.
// ----------------------------------------------------------------------------
module ftfm_merge import ftfm_pkg::*; #(
  parameter int AW = 10
) (
  input  logic [SLOTS-1:0]                in_range,
  input  logic [SLOTS-1:0]                owned,
  input  logic [SLOTS-1:0][AW-1:0]        row,
  input  logic [SLOTS-1:0][ROW_BITS-1:0]  bit_sel,
  input  logic [SLOTS-1:0][ROW_W-1:0]     rd_data,
  output logic [SLOTS-1:0]                claim,
  output logic [SLOTS-1:0][ROW_W-1:0]     new_row
);

  always_comb begin
    logic dup;
    for (int k = 0; k < SLOTS; k++) begin
      dup = 1'b0;
      // an earlier slot naming the same feature takes it first
      for (int j = 0; j < k; j++) begin
        if (in_range[j] && row[j] == row[k] && bit_sel[j] == bit_sel[k]) begin
          dup = 1'b1;
        end
      end
      claim[k] = in_range[k] && !owned[k] && !dup;
    end
    // fold every claim that lands in the same row, so repeated row writes agree
    for (int k = 0; k < SLOTS; k++) begin
      new_row[k] = rd_data[k];
      for (int j = 0; j < SLOTS; j++) begin
        if (claim[j] && row[j] == row[k]) begin
          new_row[k][bit_sel[j]] = 1'b1;
        end
      end
    end
  end

endmodule
